// ----- design/eos_pkg.sv -----
// Shared types and constants for the encoder odometer speed filter.
// Payload structs, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eos_pkg;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] pulse_count;
  } eos_in_t;

  typedef struct packed {
    logic [15:0] speed_cm_s;
    logic [31:0] distance_cm;
    logic [15:0] raw_speed;
  } eos_out_t;

  // Configuration register indexes
  localparam logic [1:0] CfgDistPerPulse = 2'd0;
  localparam logic [1:0] CfgSamplePeriod = 2'd1;
  localparam logic [1:0] CfgMinPulses    = 2'd2;
  localparam logic [1:0] CfgSmoothShift  = 2'd3;

  // Request opcodes
  localparam logic OpSample = 1'b0;
  localparam logic OpClear  = 1'b1;

  // Hundredths of a millimetre per centimetre
  localparam logic [10:0] UnitsPerCm = 11'd1000;

  localparam logic [15:0] RstDistPerPulse = 16'd100;
  localparam logic [9:0]  RstSamplePeriod = 10'd100;
  localparam logic [7:0]  RstMinPulses    = 8'd2;
  localparam logic [3:0]  RstSmoothShift  = 4'd3;

endpackage

`default_nettype wire

// ----- design/encoder_odometer_speed_filter.sv -----
// Encoder odometer with low-pass speed filter, top level.
// Depends on eos_pkg for payload structs, register indexes and constants.
//
// Usage: each request on the in_ channel carries an opcode and a signed pulse
// count; each request yields exactly one result on the out_ channel with the
// filtered speed, the accumulated distance and the raw speed.
// A sample request runs a shift-add multiplier (one multiplier bit per cycle),
// an accumulate step, then two restoring dividers side by side (one quotient
// bit per cycle: by 1000 for the distance carry and by the sample period for
// the raw speed), then an update step that waits for the output register. A
// clear request goes straight to the update step. One request is in work at a
// time and in_ready returns the cycle after the update, so the block takes no
// new request until the last one has left its update step.
// The result sits in an output register: a stalled receiver holds out_valid
// and out_data steady, and the block still accepts and works on the next
// request, waiting in its update cycle until the output register is free.
// Synchronous active-low reset clears distance, remainder and both speeds, and restores
// the configuration registers to their defaults. Configuration writes take effect at once;
// the user must make them only while the block is idle, as the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module encoder_odometer_speed_filter (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  eos_pkg::eos_in_t      in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output eos_pkg::eos_out_t     out_data,
  input  wire                   cfg_we,
  input  wire  [1:0]            cfg_index,
  input  wire  [15:0]           cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ADD  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] dpp_r;
  logic [9:0]  period_r;
  logic [7:0]  min_r;
  logic [3:0]  shift_r;

  logic [31:0] dist_r, dist_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [15:0] filt_r, filt_nxt;
  logic [15:0] last_raw_r, last_raw_nxt;

  logic        clear_r, clear_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] prod_r, prod_nxt;   // product, then speed dividend/quotient
  logic [31:0] qa_r, qa_nxt;       // distance dividend/quotient
  logic [9:0]  ra_r, ra_nxt;
  logic [9:0]  rs_r, rs_nxt;
  logic [9:0]  div_r, div_nxt;

  logic              out_valid_r, out_valid_nxt;
  eos_pkg::eos_out_t out_data_r, out_data_nxt;

  logic        accept;
  logic        below;
  logic [14:0] pulses;
  logic [16:0] mul_sum;
  logic [10:0] trial_a, trial_s;
  logic        ge_a, ge_s;
  logic [15:0] raw;
  logic signed [15:0] diff_s;
  logic [15:0] step;
  logic        out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Negative counts and counts under the threshold contribute nothing
  assign below  = in_data.pulse_count[15] || ({1'b0, in_data.pulse_count[14:0]} < {8'd0, min_r});
  assign pulses = below ? 15'd0 : in_data.pulse_count[14:0];

  assign mul_sum = {1'b0, prod_r[31:16]} + (prod_r[0] ? {1'b0, dpp_r} : 17'd0);

  assign trial_a = {ra_r, qa_r[31]};
  assign ge_a    = (trial_a >= eos_pkg::UnitsPerCm);
  assign trial_s = {rs_r, prod_r[31]};
  assign ge_s    = (trial_s >= {1'b0, div_r});

  assign raw    = prod_r[15:0];
  assign diff_s = raw - filt_r;
  assign step   = 16'(diff_s >>> shift_r);

  always_comb begin
    state_nxt     = state_r;
    dist_nxt      = dist_r;
    rem_nxt       = rem_r;
    filt_nxt      = filt_r;
    last_raw_nxt  = last_raw_r;
    clear_nxt     = clear_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    qa_nxt        = qa_r;
    ra_nxt        = ra_r;
    rs_nxt        = rs_r;
    div_nxt       = div_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          clear_nxt = (in_data.opcode == eos_pkg::OpClear);
          cnt_nxt   = 5'd0;
          prod_nxt  = {17'd0, pulses};
          div_nxt   = (period_r == 10'd0) ? 10'd1 : period_r;
          state_nxt = (in_data.opcode == eos_pkg::OpClear) ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        // Add the multiplicand under the low bit, shift the product right
        prod_nxt = {mul_sum, prod_r[15:1]};
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        qa_nxt    = {22'd0, rem_r} + prod_r;
        ra_nxt    = 10'd0;
        rs_nxt    = 10'd0;
        cnt_nxt   = 5'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ra_nxt   = ge_a ? 10'(trial_a - eos_pkg::UnitsPerCm) : trial_a[9:0];
        qa_nxt   = {qa_r[30:0], ge_a};
        rs_nxt   = ge_s ? 10'(trial_s - {1'b0, div_r}) : trial_s[9:0];
        prod_nxt = {prod_r[30:0], ge_s};
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Hold here until the output register can take the result
        if (out_free) begin
          if (clear_r) begin
            dist_nxt = 32'd0;
            rem_nxt  = 10'd0;
          end else begin
            dist_nxt     = dist_r + qa_r;
            rem_nxt      = ra_r;
            last_raw_nxt = raw;
            if (filt_r == 16'd0 && raw != 16'd0) begin
              filt_nxt = raw;
            end else begin
              filt_nxt = filt_r + step;
            end
          end
          out_data_nxt.speed_cm_s  = clear_r ? filt_r : filt_nxt;
          out_data_nxt.distance_cm = clear_r ? 32'd0 : dist_nxt;
          out_data_nxt.raw_speed   = clear_r ? last_raw_r : last_raw_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dist_r      <= 32'd0;
      rem_r       <= 10'd0;
      filt_r      <= 16'd0;
      last_raw_r  <= 16'd0;
      dpp_r       <= eos_pkg::RstDistPerPulse;
      period_r    <= eos_pkg::RstSamplePeriod;
      min_r       <= eos_pkg::RstMinPulses;
      shift_r     <= eos_pkg::RstSmoothShift;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dist_r      <= dist_nxt;
      rem_r       <= rem_nxt;
      filt_r      <= filt_nxt;
      last_raw_r  <= last_raw_nxt;
      if (cfg_we) begin
        case (cfg_index)
          eos_pkg::CfgDistPerPulse: dpp_r    <= cfg_wdata;
          eos_pkg::CfgSamplePeriod: period_r <= cfg_wdata[9:0];
          eos_pkg::CfgMinPulses:    min_r    <= cfg_wdata[7:0];
          eos_pkg::CfgSmoothShift:  shift_r  <= cfg_wdata[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    clear_r    <= clear_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    qa_r       <= qa_nxt;
    ra_r       <= ra_nxt;
    rs_r       <= rs_nxt;
    div_r      <= div_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
